@@ sv/nimh_module_supervisor_core_defines.svh @@
// assertion macros shared by the checker
`ifndef NIMH_MODULE_SUPERVISOR_CORE_DEFINES_SVH
`define NIMH_MODULE_SUPERVISOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NMSUP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NMSUP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/nmsup_pkg.sv @@
package nmsup_pkg;

	// block sizing
	localparam int MODULES        = 16;
	localparam int WINDOW_SAMPLES = 8;

	// fixed field widths
	localparam int MOD_IDX_W  = 4;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// derived widths
	localparam int MOD_ADDR_W = (MODULES > 1) ? $clog2(MODULES) : 1;
	localparam int WIN_CNT_W  = $clog2(WINDOW_SAMPLES);
	localparam int CHG_CNT_W  = $clog2(2 * MODULES + 1);
	localparam int LOAD_CNT_W = $clog2(MODULES + 1);
	localparam int RANGE_W    = SAMPLE_W + 1;
	localparam int PROD_W     = RANGE_W + 4;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_INIT        = 3'd0,
		MODE_CHARGING    = 3'd1,
		MODE_CHARGED     = 3'd2,
		MODE_CRITICAL    = 3'd3,
		MODE_DISCHARGING = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		TF_NONE = 2'd0,
		TF_HIGH = 2'd1,
		TF_LOW  = 2'd2
	} tfault_t;

	typedef enum logic [1:0] {
		VF_NONE  = 2'd0,
		VF_OVER  = 2'd1,
		VF_UNDER = 2'd2
	} vfault_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_VOLT_UPPER = 2'd0,
		REG_VOLT_LOWER = 2'd1,
		REG_TEMP_UPPER = 2'd2,
		REG_TEMP_LOWER = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]        volt_upper;
		logic [SAMPLE_W-1:0]        volt_lower;
		logic signed [SAMPLE_W-1:0] temp_upper;
		logic signed [SAMPLE_W-1:0] temp_lower;
	} limits_t;

	// classified sample as held in the queue
	typedef struct packed {
		logic [MOD_IDX_W-1:0]       module_index;
		logic [MOD_ADDR_W-1:0]      addr;
		logic                       rejected;
		logic signed [SAMPLE_W-1:0] temp;
		logic [SAMPLE_W-1:0]        volt;
	} q_item_t;

endpackage

@@ sv/nmsup_ifs.sv @@
// sample channel
interface nmsup_sample_if;
	import nmsup_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [MOD_IDX_W-1:0]       module_index;
	logic signed [SAMPLE_W-1:0] temperature_sample;
	logic [SAMPLE_W-1:0]        voltage_sample;
	modport source (output valid, module_index, temperature_sample, voltage_sample,
		input ready);
	modport sink (input valid, module_index, temperature_sample, voltage_sample,
		output ready);
endinterface

// result channel
interface nmsup_result_if;
	import nmsup_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MOD_IDX_W-1:0] module_echo;
	logic [2:0]           charge_state;
	logic [1:0]           temp_fault;
	logic [1:0]           volt_fault;
	logic                 window_closed;
	logic                 charger_on;
	logic                 load_on;
	logic                 rejected;
	modport source (output valid, module_echo, charge_state, temp_fault, volt_fault,
		window_closed, charger_on, load_on, rejected, input ready);
	modport sink (input valid, module_echo, charge_state, temp_fault, volt_fault,
		window_closed, charger_on, load_on, rejected, output ready);
endinterface

// register write channel
interface nmsup_cfg_if;
	import nmsup_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

@@ sv/nmsup_front.sv @@
module nmsup_front (
	nmsup_sample_if.sink        samples,
	output logic                push_valid,
	output nmsup_pkg::q_item_t  push_item,
	input  logic                push_ready
);
	import nmsup_pkg::*;

	// accept whenever the queue has room
	assign samples.ready = push_ready;
	assign push_valid    = samples.valid;

	// classify: range check and storage address
	always_comb begin
		push_item.module_index = samples.module_index;
		push_item.addr         = MOD_ADDR_W'(samples.module_index);
		push_item.rejected     = (int'(samples.module_index) >= MODULES);
		push_item.temp         = samples.temperature_sample;
		push_item.volt         = samples.voltage_sample;
	end

endmodule

@@ sv/nmsup_queue.sv @@
module nmsup_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  nmsup_pkg::q_item_t push_item,
	output logic               push_ready,
	output logic               pop_valid,
	output nmsup_pkg::q_item_t pop_item,
	input  logic               pop_ready
);
	import nmsup_pkg::*;

	q_item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

@@ sv/nmsup_back.sv @@
module nmsup_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  nmsup_pkg::q_item_t pop_item,
	output logic               pop_ready,
	input  nmsup_pkg::limits_t limits,
	nmsup_result_if.source     results
);
	import nmsup_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] temp_t;
	typedef logic [SAMPLE_W-1:0]        volt_t;
	typedef logic signed [RANGE_W-1:0]  range_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	// window statistics per module
	logic [WIN_CNT_W-1:0] win_cnt_q   [MODULES];
	temp_t                tmax_now_q  [MODULES];
	temp_t                tmin_now_q  [MODULES];
	temp_t                tmax_bef_q  [MODULES];
	temp_t                tmin_bef_q  [MODULES];
	volt_t                vmax_now_q  [MODULES];
	volt_t                vmin_now_q  [MODULES];
	volt_t                vmax_bef_q  [MODULES];
	volt_t                vmin_bef_q  [MODULES];

	// mode and fault state per module, block counts
	mode_t                mode_q      [MODULES];
	tfault_t              tf_q        [MODULES];
	vfault_t              vf_q        [MODULES];
	logic [CHG_CNT_W-1:0]  chg_cnt_q;
	logic [LOAD_CNT_W-1:0] load_cnt_q;

	// stage 1 pipeline registers
	logic                  valid_s1;
	logic [MOD_IDX_W-1:0]  module_s1;
	logic [MOD_ADDR_W-1:0] addr_s1;
	logic                  rejected_s1;
	logic                  closed_s1;
	temp_t                 tmax_now_s1, tmin_now_s1, tmax_bef_s1, tmin_bef_s1;
	volt_t                 vmax_now_s1, vmin_now_s1, vmax_bef_s1, vmin_bef_s1;
	logic                  bef_pos_s1;
	prod_t                 bef_x_s1;

	// stage 2 (result) registers
	logic                  valid_s2;
	logic [MOD_IDX_W-1:0]  module_s2;
	logic [2:0]            state_s2;
	logic [1:0]            tf_s2;
	logic [1:0]            vf_s2;
	logic                  closed_s2;
	logic                  chg_on_s2;
	logic                  load_on_s2;
	logic                  rejected_s2;

	// stage 1 combinational
	logic                  advance;
	logic                  take;
	logic [MOD_ADDR_W-1:0] a1;
	logic [WIN_CNT_W-1:0]  cnt;
	logic                  first;
	logic                  closing;
	temp_t                 tmax_new, tmin_new;
	volt_t                 vmax_new, vmin_new;
	range_t                bef_rng;
	prod_t                 bef_ext;

	// stage 2 combinational
	logic                  act;
	mode_t                 mode_n;
	tfault_t               tf_n, tf_new;
	vfault_t               vf_n, vf_new;
	logic [CHG_CNT_W-1:0]  chg_n;
	logic [LOAD_CNT_W-1:0] load_n;
	logic                  rising;
	logic                  dtdt;
	range_t                now_rng;
	prod_t                 now_ext;
	prod_t                 now_x;

	// whole back pipeline moves when the result slot is free or drains
	assign advance   = !valid_s2 || results.ready;
	assign pop_ready = advance;
	assign take      = pop_valid && advance;

	// stage 1: window min/max update
	always_comb begin
		a1       = pop_item.addr;
		cnt      = win_cnt_q[a1];
		first    = (cnt == '0);
		closing  = (cnt == WIN_CNT_W'(WINDOW_SAMPLES - 1));
		tmax_new = (first || pop_item.temp > tmax_now_q[a1]) ? pop_item.temp : tmax_now_q[a1];
		tmin_new = (first || pop_item.temp < tmin_now_q[a1]) ? pop_item.temp : tmin_now_q[a1];
		vmax_new = (first || pop_item.volt > vmax_now_q[a1]) ? pop_item.volt : vmax_now_q[a1];
		vmin_new = (first || pop_item.volt < vmin_now_q[a1]) ? pop_item.volt : vmin_now_q[a1];
		// previous window range, widened; scaled by 15 into bef_x_s1
		bef_rng  = RANGE_W'(tmax_bef_q[a1]) - RANGE_W'(tmin_bef_q[a1]);
		bef_ext  = PROD_W'(bef_rng);
	end

	// stage 1 state, written once per transfer into the pipeline that is not rejected
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODULES; i++) begin
				win_cnt_q[i]  <= '0;
				tmax_now_q[i] <= '0;
				tmin_now_q[i] <= '0;
				tmax_bef_q[i] <= '0;
				tmin_bef_q[i] <= '0;
				vmax_now_q[i] <= '0;
				vmin_now_q[i] <= '0;
				vmax_bef_q[i] <= '0;
				vmin_bef_q[i] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			if (advance) valid_s1 <= pop_valid;
			if (take && !pop_item.rejected) begin
				win_cnt_q[a1]  <= closing ? '0 : cnt + 1'b1;
				tmax_now_q[a1] <= tmax_new;
				tmin_now_q[a1] <= tmin_new;
				vmax_now_q[a1] <= vmax_new;
				vmin_now_q[a1] <= vmin_new;
				if (closing) begin
					tmax_bef_q[a1] <= tmax_new;
					tmin_bef_q[a1] <= tmin_new;
					vmax_bef_q[a1] <= vmax_new;
					vmin_bef_q[a1] <= vmin_new;
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			module_s1   <= pop_item.module_index;
			addr_s1     <= a1;
			rejected_s1 <= pop_item.rejected;
			closed_s1   <= closing && !pop_item.rejected;
			tmax_now_s1 <= tmax_new;
			tmin_now_s1 <= tmin_new;
			vmax_now_s1 <= vmax_new;
			vmin_now_s1 <= vmin_new;
			tmax_bef_s1 <= tmax_bef_q[a1];
			tmin_bef_s1 <= tmin_bef_q[a1];
			vmax_bef_s1 <= vmax_bef_q[a1];
			vmin_bef_s1 <= vmin_bef_q[a1];
			bef_pos_s1  <= (bef_rng > 0);
			bef_x_s1    <= (bef_ext <<< 4) - bef_ext;
		end
	end

	// stage 2: fault classification, block counts, charge state
	always_comb begin
		act     = valid_s1 && closed_s1;
		mode_n  = mode_q[addr_s1];
		tf_n    = tf_q[addr_s1];
		vf_n    = vf_q[addr_s1];
		chg_n   = chg_cnt_q;
		load_n  = load_cnt_q;
		tf_new  = TF_NONE;
		vf_new  = VF_NONE;
		rising  = (tmax_now_s1 > tmax_bef_s1) || (tmin_now_s1 > tmin_bef_s1) ||
			(vmax_now_s1 >= vmax_bef_s1) || (vmin_now_s1 >= vmin_bef_s1);
		now_rng = RANGE_W'(tmax_now_s1) - RANGE_W'(tmin_now_s1);
		now_ext = PROD_W'(now_rng);
		// current range times 10
		now_x   = (now_ext <<< 3) + (now_ext <<< 1);
		dtdt    = bef_pos_s1 && (now_x > bef_x_s1);
		if (act) begin
			if (mode_n != MODE_INIT) begin
				if (tmax_now_s1 > limits.temp_upper) tf_new = TF_HIGH;
				else if (tmin_now_s1 < limits.temp_lower) tf_new = TF_LOW;
				if (tf_new != tf_n) begin
					if (tf_new == TF_HIGH) chg_n = chg_n + 1'b1;
					else if (tf_n == TF_HIGH) chg_n = chg_n - 1'b1;
				end
				tf_n = tf_new;
				if (vmax_now_s1 < limits.volt_lower) vf_new = VF_UNDER;
				else if (vmin_now_s1 > limits.volt_upper) vf_new = VF_OVER;
				if (vf_new != vf_n) begin
					if (vf_new == VF_OVER) chg_n = chg_n + 1'b1;
					else if (vf_n == VF_OVER) chg_n = chg_n - 1'b1;
					if (vf_new == VF_UNDER) load_n = load_n + 1'b1;
					else if (vf_n == VF_UNDER) load_n = load_n - 1'b1;
				end
				vf_n = vf_new;
			end
			case (mode_n)
				MODE_CRITICAL: begin
					if (tf_n == TF_NONE && vf_n == VF_NONE && !rising)
						mode_n = MODE_DISCHARGING;
				end
				MODE_INIT, MODE_DISCHARGING: begin
					mode_n = rising ? MODE_CHARGING : MODE_DISCHARGING;
				end
				MODE_CHARGING: begin
					if (dtdt) mode_n = MODE_CHARGED;
					else mode_n = rising ? MODE_CHARGING : MODE_DISCHARGING;
				end
				MODE_CHARGED: begin
					if (!rising) mode_n = MODE_DISCHARGING;
					else if (dtdt) mode_n = MODE_CRITICAL;
				end
				default: begin
					mode_n = mode_q[addr_s1];
				end
			endcase
		end
	end

	// stage 2 state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODULES; i++) begin
				mode_q[i] <= MODE_INIT;
				tf_q[i]   <= TF_NONE;
				vf_q[i]   <= VF_NONE;
			end
			chg_cnt_q  <= '0;
			load_cnt_q <= '0;
			valid_s2   <= 1'b0;
		end else begin
			if (advance) valid_s2 <= valid_s1;
			if (advance && act) begin
				mode_q[addr_s1] <= mode_n;
				tf_q[addr_s1]   <= tf_n;
				vf_q[addr_s1]   <= vf_n;
				chg_cnt_q       <= chg_n;
				load_cnt_q      <= load_n;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			module_s2   <= module_s1;
			state_s2    <= rejected_s1 ? MODE_INIT : mode_n;
			tf_s2       <= rejected_s1 ? TF_NONE : tf_n;
			vf_s2       <= rejected_s1 ? VF_NONE : vf_n;
			closed_s2   <= closed_s1;
			chg_on_s2   <= (chg_n == '0);
			load_on_s2  <= (load_n == '0);
			rejected_s2 <= rejected_s1;
		end
	end

	assign results.valid         = valid_s2;
	assign results.module_echo   = module_s2;
	assign results.charge_state  = state_s2;
	assign results.temp_fault    = tf_s2;
	assign results.volt_fault    = vf_s2;
	assign results.window_closed = closed_s2;
	assign results.charger_on    = chg_on_s2;
	assign results.load_on       = load_on_s2;
	assign results.rejected      = rejected_s2;

endmodule

@@ sv/nimh_module_supervisor_core.sv @@
// NiMH module supervisor: takes one temperature/voltage sample per clock for any of the
// battery modules while the queue has room and returns one result per sample, in order;
// a two-entry queue parts the sample side from the back pipeline, so up to two more samples
// are taken while a result waits. The sustained rate is one sample per cycle while results
// are not stalled, set by the two back stages, each a read-modify-write of its own
// per-module registers (window min/max in the first, mode, faults and relay block counts in
// the second). Per-module state and valid flags are cleared at reset, with no clearing pass.
// The four limit registers are written through the cfg channel, which is always ready; the
// user must write them only while no sample is in flight, as the block does not enforce it.
module nimh_module_supervisor_core (
	input  logic           clk,
	input  logic           arst_n,
	nmsup_sample_if.sink   samples,
	nmsup_result_if.source results,
	nmsup_cfg_if.sink      cfg
);
	import nmsup_pkg::*;

	logic    push_valid;
	logic    push_ready;
	q_item_t push_item;
	logic    pop_valid;
	logic    pop_ready;
	q_item_t pop_item;
	limits_t limits_q;

	// limit registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.volt_upper <= '1;
			limits_q.volt_lower <= '0;
			limits_q.temp_upper <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			limits_q.temp_lower <= {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.addr))
				REG_VOLT_UPPER: limits_q.volt_upper <= cfg.data;
				REG_VOLT_LOWER: limits_q.volt_lower <= cfg.data;
				REG_TEMP_UPPER: limits_q.temp_upper <= cfg.data;
				REG_TEMP_LOWER: limits_q.temp_lower <= cfg.data;
				default: limits_q <= limits_q;
			endcase
		end
	end

	// front: accept and classify
	nmsup_front u_front (
		.samples    (samples),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	// decoupling queue
	nmsup_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// back: window tracking and supervision
	nmsup_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.limits    (limits_q),
		.results   (results)
	);

endmodule

@@ sv/nmsup_checker.sv @@
`include "nimh_module_supervisor_core_defines.svh"

module nmsup_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] res_module_echo,
	input logic [2:0] res_charge_state,
	input logic [1:0] res_temp_fault,
	input logic [1:0] res_volt_fault,
	input logic       res_window_closed,
	input logic       res_charger_on,
	input logic       res_load_on,
	input logic       res_rejected
);
	import nmsup_pkg::*;

	// stalled result holds
	`NMSUP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({res_module_echo, res_charge_state, res_temp_fault, res_volt_fault, res_window_closed, res_charger_on, res_load_on, res_rejected}), "result changed while stalled")

	// a rejected sample reports no state
	`NMSUP_ASSERT_NOW(a_rej_clean, res_valid && res_rejected, res_charge_state == MODE_INIT && res_temp_fault == TF_NONE && res_volt_fault == VF_NONE, "rejected result carries state")

	// a rejected sample never closes a window
	`NMSUP_ASSERT_NOW(a_rej_open, res_valid && res_rejected, !res_window_closed, "rejected result closed a window")

	// a closed window leaves its module in a real charge state
	`NMSUP_ASSERT_NOW(a_closed_mode, res_valid && res_window_closed, res_charge_state != MODE_INIT, "closed window left module in init")

endmodule

bind nimh_module_supervisor_core nmsup_checker u_nmsup_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (results.valid),
	.res_ready         (results.ready),
	.res_module_echo   (results.module_echo),
	.res_charge_state  (results.charge_state),
	.res_temp_fault    (results.temp_fault),
	.res_volt_fault    (results.volt_fault),
	.res_window_closed (results.window_closed),
	.res_charger_on    (results.charger_on),
	.res_load_on       (results.load_on),
	.res_rejected      (results.rejected)
);
